/* hdl/ddict_pkg.sv */
// Shared types, sizes and constants for the dense id dictionary.
`default_nettype none
package ddict_pkg;

  localparam int ENTITY_SLOTS   = 4096;
  localparam int RELATION_SLOTS = 1024;
  localparam int KEY_BITS       = 32;
  localparam int ID_W           = 12;

  localparam int ENT_IDX_W = $clog2(ENTITY_SLOTS);
  localparam int ENT_CNT_W = $clog2(ENTITY_SLOTS + 1);
  localparam int REL_IDX_W = $clog2(RELATION_SLOTS);
  localparam int REL_CNT_W = $clog2(RELATION_SLOTS + 1);
  localparam int SCAN_W    = (ENT_CNT_W > REL_CNT_W) ? ENT_CNT_W : REL_CNT_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [ENT_IDX_W-1:0] ent_idx_t;
  typedef logic [ENT_CNT_W-1:0] ent_cnt_t;
  typedef logic [REL_IDX_W-1:0] rel_idx_t;
  typedef logic [REL_CNT_W-1:0] rel_cnt_t;
  typedef logic [SCAN_W-1:0]    scan_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QCNT_W-1:0]    qcnt_t;

  localparam ent_cnt_t ENT_FULL = ent_cnt_t'(ENTITY_SLOTS);
  localparam rel_cnt_t REL_FULL = rel_cnt_t'(RELATION_SLOTS);
  localparam qcnt_t    Q_FULL   = qcnt_t'(QDEPTH);
  localparam qptr_t    Q_LAST   = qptr_t'(QDEPTH - 1);

  localparam logic SEL_ENTITY   = 1'b0;
  localparam logic SEL_RELATION = 1'b1;

  typedef struct packed {
    logic sel;
    key_t key;
  } q_entry_t;

endpackage
`default_nettype wire

/* hdl/dense_id_dictionary.sv */
// Top level of the dense id dictionary: request queue front end and key scan back end.
//
//  channel   | handshake             | fields
//  ----------+-----------------------+-------------------------------------
//  request   | start in, busy out    | table_select, ext_key
//  result    | done out (strobe)     | dense_id, was_new, table_full
//
// A request is taken when start is high and busy is low; up to two wait in the queue.
// Back end: a hit ends the scan early, a miss scans every stored key; one stored key is
// read and compared per cycle, done follows next cycle.
// Worst case is a miss on a full entity table.
// Results appear on done for one cycle and cannot be held off.
// Synchronous reset empties the queue and both tables; key RAMs are not cleared.
`default_nettype none
module dense_id_dictionary (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        table_select,
  input  wire logic [31:0] ext_key,
  output logic             done,
  output logic [11:0]      dense_id,
  output logic             was_new,
  output logic             table_full
);

  logic                q_valid;
  logic                q_pop;
  ddict_pkg::q_entry_t q_head;

  ddict_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .table_select (table_select),
    .ext_key      (ext_key),
    .q_pop        (q_pop),
    .q_valid      (q_valid),
    .q_head       (q_head)
  );

  ddict_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .dense_id    (dense_id),
    .was_new     (was_new),
    .table_full  (table_full)
  );

endmodule
`default_nettype wire

/* hdl/ddict_front.sv */
// Front end: accepts requests and queues the table select and key for the lookup engine.
`default_nettype none
module ddict_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                table_select,
  input  wire logic [31:0]         ext_key,
  input  wire logic                q_pop,
  output logic                     q_valid,
  output ddict_pkg::q_entry_t      q_head
);

  ddict_pkg::q_entry_t ents [ddict_pkg::QDEPTH];
  ddict_pkg::qptr_t    wr_ptr;
  ddict_pkg::qptr_t    rd_ptr;
  ddict_pkg::qcnt_t    qcnt;
  logic                push;

  assign busy    = (qcnt == ddict_pkg::Q_FULL);
  assign push    = start && !busy;
  assign q_valid = (qcnt != '0);
  assign q_head  = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr].sel <= table_select;
      ents[wr_ptr].key <= ddict_pkg::key_t'(ext_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ddict_pkg::Q_LAST) ? '0 : wr_ptr + ddict_pkg::qptr_t'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == ddict_pkg::Q_LAST) ? '0 : rd_ptr + ddict_pkg::qptr_t'(1);
      end
      unique case ({push, q_pop})
        2'b10:   qcnt <= qcnt + ddict_pkg::qcnt_t'(1);
        2'b01:   qcnt <= qcnt - ddict_pkg::qcnt_t'(1);
        default: qcnt <= qcnt;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/ddict_back.sv */
// Back end: key stores, id counters and the linear key scan that resolves each request.
`default_nettype none
module ddict_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire ddict_pkg::q_entry_t q_head,
  output logic                     q_pop,
  output logic                     done,
  output logic [11:0]              dense_id,
  output logic                     was_new,
  output logic                     table_full
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                state;
  ddict_pkg::q_entry_t   cur;
  ddict_pkg::scan_t      rd_cnt;
  ddict_pkg::scan_t      cmp_idx;
  logic                  cmp_valid;
  ddict_pkg::ent_cnt_t   entity_next;
  ddict_pkg::rel_cnt_t   relation_next;

  ddict_pkg::key_t       ent_mem [ddict_pkg::ENTITY_SLOTS];
  ddict_pkg::key_t       rel_mem [ddict_pkg::RELATION_SLOTS];
  ddict_pkg::key_t       ent_rdata;
  ddict_pkg::key_t       rel_rdata;

  ddict_pkg::scan_t      cur_lim;
  ddict_pkg::key_t       cmp_key;
  logic                  issue;
  logic                  hit;
  logic                  miss;
  logic                  is_full;
  logic                  ent_we;
  logic                  rel_we;

  always_comb begin
    cur_lim = (cur.sel == ddict_pkg::SEL_RELATION) ? ddict_pkg::scan_t'(relation_next)
                                                   : ddict_pkg::scan_t'(entity_next);
    cmp_key = (cur.sel == ddict_pkg::SEL_RELATION) ? rel_rdata : ent_rdata;
    is_full = (cur.sel == ddict_pkg::SEL_RELATION) ? (relation_next == ddict_pkg::REL_FULL)
                                                   : (entity_next == ddict_pkg::ENT_FULL);
    issue   = (state == S_SCAN) && (rd_cnt < cur_lim);
    hit     = (state == S_SCAN) && cmp_valid && (cmp_key == cur.key);
    miss    = (state == S_SCAN) && !cmp_valid && !issue;
    ent_we  = miss && !is_full && (cur.sel == ddict_pkg::SEL_ENTITY);
    rel_we  = miss && !is_full && (cur.sel == ddict_pkg::SEL_RELATION);
    q_pop   = (state == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[entity_next[ddict_pkg::ENT_IDX_W-1:0]] <= cur.key;
    end
    ent_rdata <= ent_mem[rd_cnt[ddict_pkg::ENT_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[relation_next[ddict_pkg::REL_IDX_W-1:0]] <= cur.key;
    end
    rel_rdata <= rel_mem[rd_cnt[ddict_pkg::REL_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      cmp_valid     <= 1'b0;
      entity_next   <= '0;
      relation_next <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_head;
            rd_cnt    <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          cmp_idx   <= rd_cnt;
          if (issue) begin
            rd_cnt <= rd_cnt + ddict_pkg::scan_t'(1);
          end
          if (hit) begin
            done        <= 1'b1;
            dense_id    <= ddict_pkg::id_t'(cmp_idx);
            was_new     <= 1'b0;
            table_full  <= 1'b0;
            state       <= S_IDLE;
          end else if (miss) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (is_full) begin
              dense_id    <= '0;
              was_new     <= 1'b0;
              table_full  <= 1'b1;
            end else begin
              dense_id    <= ddict_pkg::id_t'(cur_lim);
              was_new     <= 1'b1;
              table_full  <= 1'b0;
              if (cur.sel == ddict_pkg::SEL_RELATION) begin
                relation_next <= relation_next + ddict_pkg::rel_cnt_t'(1);
              end else begin
                entity_next <= entity_next + ddict_pkg::ent_cnt_t'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/ddict_checker.sv */
// Port-level checks for the dense id dictionary, bound to the top level.
`default_nettype none
module ddict_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [11:0] dense_id,
  input wire logic        was_new,
  input wire logic        table_full
);

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (dense_id == 12'd0 && !was_new))
    else $error("full result carries an id or new flag");

  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    (done && was_new) |-> !table_full)
    else $error("new and full flagged together");

  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy right after reset");

endmodule

bind dense_id_dictionary ddict_checker u_ddict_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .dense_id    (dense_id),
  .was_new     (was_new),
  .table_full  (table_full)
);
`default_nettype wire
